// ----- rtl/mipsdec_pkg.sv -----
// Types, codes and lookup tables shared by the instruction decoder files.
package mipsdec_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_COP2    = 6'h12;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;
  localparam logic [5:0] OP_LWC2    = 6'h32;
  localparam logic [5:0] OP_SWC2    = 6'h3A;

  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_RFE     = 6'h10;

  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZ    = 5'h01;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  localparam logic [4:0] RS_MF      = 5'h00;
  localparam logic [4:0] RS_CF      = 5'h02;
  localparam logic [4:0] RS_MT      = 5'h04;
  localparam logic [4:0] RS_CT      = 5'h06;
  localparam logic [4:0] RS_CO      = 5'h10;
  localparam logic [4:0] REG_RA     = 5'd31;

  localparam logic [6:0] ID_UNKNOWN     = 7'd0;
  localparam logic [6:0] ID_SPECIAL_UNK = 7'd29;
  localparam logic [6:0] ID_BLTZ        = 7'd30;
  localparam logic [6:0] ID_BGEZ        = 7'd31;
  localparam logic [6:0] ID_BLTZAL      = 7'd32;
  localparam logic [6:0] ID_BGEZAL      = 7'd33;
  localparam logic [6:0] ID_REGIMM_UNK  = 7'd34;
  localparam logic [6:0] ID_MFC0        = 7'd35;
  localparam logic [6:0] ID_MTC0        = 7'd36;
  localparam logic [6:0] ID_RFE         = 7'd37;
  localparam logic [6:0] ID_COP0_CO     = 7'd38;
  localparam logic [6:0] ID_COP0_OTHER  = 7'd39;
  localparam logic [6:0] ID_MFC2        = 7'd40;
  localparam logic [6:0] ID_CFC2        = 7'd41;
  localparam logic [6:0] ID_MTC2        = 7'd42;
  localparam logic [6:0] ID_CTC2        = 7'd43;
  localparam logic [6:0] ID_GTE         = 7'd44;
  localparam logic [6:0] ID_COP2_OTHER  = 7'd45;
  localparam logic [6:0] ID_NOP         = 7'd74;

  localparam logic [2:0] FMT_UNKNOWN = 3'd0;
  localparam logic [2:0] FMT_I       = 3'd1;
  localparam logic [2:0] FMT_J       = 3'd2;
  localparam logic [2:0] FMT_SPECIAL = 3'd3;
  localparam logic [2:0] FMT_REGIMM  = 3'd4;
  localparam logic [2:0] FMT_COP0    = 3'd5;
  localparam logic [2:0] FMT_COP2    = 3'd6;

  localparam logic [9:0] FLAG_NONE    = 10'h000;
  localparam logic [9:0] FLAG_BRANCH  = 10'h001;
  localparam logic [9:0] FLAG_JUMP    = 10'h002;
  localparam logic [9:0] FLAG_LOAD    = 10'h004;
  localparam logic [9:0] FLAG_STORE   = 10'h008;
  localparam logic [9:0] FLAG_ALU     = 10'h010;
  localparam logic [9:0] FLAG_NOP     = 10'h020;
  localparam logic [9:0] FLAG_SYSCALL = 10'h040;
  localparam logic [9:0] FLAG_BREAK   = 10'h080;
  localparam logic [9:0] FLAG_JR_RA   = 10'h100;
  localparam logic [9:0] FLAG_DELAY   = 10'h200;

  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_address;
  } in_req_t;

  typedef struct packed {
    logic [6:0]         op_id;
    logic [2:0]         format_code;
    logic [9:0]         class_flags;
    logic [31:0]        target_addr;
    logic [5:0]         major_op;
    logic [4:0]         src_reg;
    logic [4:0]         tgt_reg;
    logic [4:0]         dst_reg;
    logic [4:0]         shift_amt;
    logic [5:0]         func_code;
    logic signed [15:0] imm_value;
  } out_req_t;

  typedef struct packed {
    logic [6:0] op_id;
    logic [2:0] format_code;
    logic [9:0] class_flags;
  } dec_class_t;

  function automatic logic [6:0] special_id(input logic [5:0] fn);
    logic [6:0] id;
    case (fn)
      6'h00: id = 7'd1;
      6'h02: id = 7'd2;
      6'h03: id = 7'd3;
      6'h04: id = 7'd4;
      6'h06: id = 7'd5;
      6'h07: id = 7'd6;
      6'h08: id = 7'd7;
      6'h09: id = 7'd8;
      6'h0C: id = 7'd9;
      6'h0D: id = 7'd10;
      6'h10: id = 7'd11;
      6'h11: id = 7'd12;
      6'h12: id = 7'd13;
      6'h13: id = 7'd14;
      6'h18: id = 7'd15;
      6'h19: id = 7'd16;
      6'h1A: id = 7'd17;
      6'h1B: id = 7'd18;
      6'h20: id = 7'd19;
      6'h21: id = 7'd20;
      6'h22: id = 7'd21;
      6'h23: id = 7'd22;
      6'h24: id = 7'd23;
      6'h25: id = 7'd24;
      6'h26: id = 7'd25;
      6'h27: id = 7'd26;
      6'h2A: id = 7'd27;
      6'h2B: id = 7'd28;
      default: id = ID_UNKNOWN;
    endcase
    return id;
  endfunction

  function automatic logic [6:0] primary_id(input logic [5:0] op);
    logic [6:0] id;
    case (op)
      6'h02: id = 7'd46;
      6'h03: id = 7'd47;
      6'h04: id = 7'd48;
      6'h05: id = 7'd49;
      6'h06: id = 7'd50;
      6'h07: id = 7'd51;
      6'h08: id = 7'd52;
      6'h09: id = 7'd53;
      6'h0A: id = 7'd54;
      6'h0B: id = 7'd55;
      6'h0C: id = 7'd56;
      6'h0D: id = 7'd57;
      6'h0E: id = 7'd58;
      6'h0F: id = 7'd59;
      6'h20: id = 7'd60;
      6'h21: id = 7'd61;
      6'h22: id = 7'd62;
      6'h23: id = 7'd63;
      6'h24: id = 7'd64;
      6'h25: id = 7'd65;
      6'h26: id = 7'd66;
      6'h28: id = 7'd67;
      6'h29: id = 7'd68;
      6'h2A: id = 7'd69;
      6'h2B: id = 7'd70;
      6'h2E: id = 7'd71;
      6'h32: id = 7'd72;
      6'h3A: id = 7'd73;
      default: id = ID_UNKNOWN;
    endcase
    return id;
  endfunction

endpackage

// ----- rtl/mipsdec_chan_if.sv -----
// Valid/ready channel interface that carries one request payload.
interface mipsdec_chan_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/mipsdec_class.sv -----
// Operation id, format code and class flag decode of one instruction word.
module mipsdec_class (
  input  logic [31:0]              word,
  output mipsdec_pkg::dec_class_t  cls
);

  logic [5:0] op;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [5:0] fn;
  logic [6:0] sid;
  logic [6:0] pid;

  assign op  = word[31:26];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign fn  = word[5:0];
  assign sid = mipsdec_pkg::special_id(fn);
  assign pid = mipsdec_pkg::primary_id(op);

  always_comb begin
    cls.op_id       = mipsdec_pkg::ID_UNKNOWN;
    cls.format_code = mipsdec_pkg::FMT_UNKNOWN;
    cls.class_flags = mipsdec_pkg::FLAG_NONE;
    case (op)
      mipsdec_pkg::OP_SPECIAL: begin
        if (sid != mipsdec_pkg::ID_UNKNOWN) begin
          cls.op_id       = sid;
          cls.format_code = mipsdec_pkg::FMT_SPECIAL;
          case (fn)
            mipsdec_pkg::FN_JR: begin
              cls.class_flags = mipsdec_pkg::FLAG_JUMP | mipsdec_pkg::FLAG_DELAY |
                                ((rs == mipsdec_pkg::REG_RA) ? mipsdec_pkg::FLAG_JR_RA
                                                             : mipsdec_pkg::FLAG_NONE);
            end
            mipsdec_pkg::FN_JALR: begin
              cls.class_flags = mipsdec_pkg::FLAG_JUMP | mipsdec_pkg::FLAG_DELAY;
            end
            mipsdec_pkg::FN_SYSCALL: cls.class_flags = mipsdec_pkg::FLAG_SYSCALL;
            mipsdec_pkg::FN_BREAK:   cls.class_flags = mipsdec_pkg::FLAG_BREAK;
            default:                 cls.class_flags = mipsdec_pkg::FLAG_ALU;
          endcase
        end else begin
          cls.op_id = mipsdec_pkg::ID_SPECIAL_UNK;
        end
      end
      mipsdec_pkg::OP_REGIMM: begin
        cls.format_code = mipsdec_pkg::FMT_REGIMM;
        cls.class_flags = mipsdec_pkg::FLAG_BRANCH | mipsdec_pkg::FLAG_DELAY;
        case (rt)
          mipsdec_pkg::RT_BLTZ:   cls.op_id = mipsdec_pkg::ID_BLTZ;
          mipsdec_pkg::RT_BGEZ:   cls.op_id = mipsdec_pkg::ID_BGEZ;
          mipsdec_pkg::RT_BLTZAL: cls.op_id = mipsdec_pkg::ID_BLTZAL;
          mipsdec_pkg::RT_BGEZAL: cls.op_id = mipsdec_pkg::ID_BGEZAL;
          default: begin
            cls.op_id       = mipsdec_pkg::ID_REGIMM_UNK;
            cls.format_code = mipsdec_pkg::FMT_UNKNOWN;
            cls.class_flags = mipsdec_pkg::FLAG_NONE;
          end
        endcase
      end
      mipsdec_pkg::OP_COP0: begin
        cls.format_code = mipsdec_pkg::FMT_COP0;
        case (rs)
          mipsdec_pkg::RS_MF: cls.op_id = mipsdec_pkg::ID_MFC0;
          mipsdec_pkg::RS_MT: cls.op_id = mipsdec_pkg::ID_MTC0;
          mipsdec_pkg::RS_CO: begin
            cls.op_id = (fn == mipsdec_pkg::FN_RFE) ? mipsdec_pkg::ID_RFE
                                                    : mipsdec_pkg::ID_COP0_CO;
          end
          default: cls.op_id = mipsdec_pkg::ID_COP0_OTHER;
        endcase
      end
      mipsdec_pkg::OP_COP2: begin
        cls.format_code = mipsdec_pkg::FMT_COP2;
        case (rs)
          mipsdec_pkg::RS_MF: cls.op_id = mipsdec_pkg::ID_MFC2;
          mipsdec_pkg::RS_CF: cls.op_id = mipsdec_pkg::ID_CFC2;
          mipsdec_pkg::RS_MT: cls.op_id = mipsdec_pkg::ID_MTC2;
          mipsdec_pkg::RS_CT: cls.op_id = mipsdec_pkg::ID_CTC2;
          default: begin
            cls.op_id = rs[4] ? mipsdec_pkg::ID_GTE : mipsdec_pkg::ID_COP2_OTHER;
          end
        endcase
      end
      default: begin
        if (pid != mipsdec_pkg::ID_UNKNOWN) begin
          cls.op_id = pid;
          if (op inside {mipsdec_pkg::OP_J, mipsdec_pkg::OP_JAL}) begin
            cls.format_code = mipsdec_pkg::FMT_J;
            cls.class_flags = mipsdec_pkg::FLAG_JUMP | mipsdec_pkg::FLAG_DELAY;
          end else begin
            cls.format_code = mipsdec_pkg::FMT_I;
            if (op inside {[mipsdec_pkg::OP_BEQ:mipsdec_pkg::OP_BGTZ]}) begin
              cls.class_flags = mipsdec_pkg::FLAG_BRANCH | mipsdec_pkg::FLAG_DELAY;
            end else if (op inside {[mipsdec_pkg::OP_ADDI:mipsdec_pkg::OP_LUI]}) begin
              cls.class_flags = mipsdec_pkg::FLAG_ALU;
            end else if (op inside {[mipsdec_pkg::OP_LB:mipsdec_pkg::OP_LWR],
                                    mipsdec_pkg::OP_LWC2}) begin
              cls.class_flags = mipsdec_pkg::FLAG_LOAD;
            end else if (op inside {mipsdec_pkg::OP_SB, mipsdec_pkg::OP_SH,
                                    mipsdec_pkg::OP_SWL, mipsdec_pkg::OP_SW,
                                    mipsdec_pkg::OP_SWR, mipsdec_pkg::OP_SWC2}) begin
              cls.class_flags = mipsdec_pkg::FLAG_STORE;
            end
          end
        end
      end
    endcase
    if (word == '0) begin
      cls.op_id       = mipsdec_pkg::ID_NOP;
      cls.class_flags = mipsdec_pkg::FLAG_NOP;
    end
  end

endmodule

// ----- rtl/mipsdec_target.sv -----
// Jump and branch target computation for one instruction word.
module mipsdec_target (
  input  logic [31:0] word,
  input  logic [31:0] address,
  output logic [31:0] target
);

  logic [5:0]  op;
  logic [31:0] pc_next;
  logic [31:0] offset;

  assign op      = word[31:26];
  assign pc_next = address + 32'd4;
  assign offset  = {{14{word[15]}}, word[15:0], 2'b00};

  always_comb begin
    if (op inside {mipsdec_pkg::OP_J, mipsdec_pkg::OP_JAL}) begin
      target = {pc_next[31:28], word[25:0], 2'b00};
    end else if (op inside {mipsdec_pkg::OP_REGIMM,
                            [mipsdec_pkg::OP_BEQ:mipsdec_pkg::OP_BGTZ]}) begin
      target = pc_next + offset;
    end else begin
      target = '0;
    end
  end

endmodule

// ----- rtl/mips_instruction_decoder.sv -----
// MIPS I instruction decoder top level with input and result registers.
//
// The instr channel takes one request per cycle unless stalled: a 32-bit
// instruction word and its address. The decoded channel returns one request per
// instruction with the operation id, format code, class flags, jump or branch
// target and the raw register, shift, funct and immediate fields.
// An accepted instruction is captured in the input register, decoded
// combinationally by the class and target logic, and written to the result
// register when that register is empty or its request is being taken; the result
// is offered from the result register. Throughput is one instruction per cycle
// while decoded.ready stays high; the two registers form a short pipeline with
// ready passed back combinationally.
// When the receiver holds decoded.ready low, the result register keeps its
// request and the input register fills; instr.ready falls only when both hold
// requests. No request is dropped or repeated.
// Reset empties both registers and leaves nothing pending.
module mips_instruction_decoder (
  input logic        clk,
  input logic        rst,
  mipsdec_chan_if.sink   instr,
  mipsdec_chan_if.source decoded
);

  logic                   in_valid;
  mipsdec_pkg::in_req_t   in_data;
  logic                   out_valid;
  mipsdec_pkg::out_req_t  out_data;
  logic                   out_ready;
  logic                   in_ready;
  mipsdec_pkg::dec_class_t cls;
  logic [31:0]            target;
  mipsdec_pkg::out_req_t  result;

  assign out_ready = !out_valid || decoded.ready;
  assign in_ready  = !in_valid || out_ready;
  assign instr.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= instr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && instr.valid) begin
      in_data <= instr.payload;
    end
  end

  mipsdec_class u_class (
    .word (in_data.instr_word),
    .cls  (cls)
  );

  mipsdec_target u_target (
    .word    (in_data.instr_word),
    .address (in_data.instr_address),
    .target  (target)
  );

  always_comb begin
    result.op_id       = cls.op_id;
    result.format_code = cls.format_code;
    result.class_flags = cls.class_flags;
    result.target_addr = target;
    result.major_op    = in_data.instr_word[31:26];
    result.src_reg     = in_data.instr_word[25:21];
    result.tgt_reg     = in_data.instr_word[20:16];
    result.dst_reg     = in_data.instr_word[15:11];
    result.shift_amt   = in_data.instr_word[10:6];
    result.func_code   = in_data.instr_word[5:0];
    result.imm_value   = in_data.instr_word[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_data <= result;
    end
  end

  assign decoded.valid   = out_valid;
  assign decoded.payload = out_data;

endmodule

// ----- rtl/mipsdec_checker.sv -----
// Port-level assertions for the instruction decoder and their bind statement.
module mipsdec_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input mipsdec_pkg::out_req_t out_payload
);

  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("Result request withdrawn while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_payload))
    else $error("Result payload changed while stalled.");

  assert property (@(posedge clk) disable iff (rst)
    (out_acc |-> pending != 2'd0) and (pending != 2'd3))
    else $error("Result count does not match accepted instructions.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.op_id == mipsdec_pkg::ID_NOP |->
      out_payload.class_flags == mipsdec_pkg::FLAG_NOP)
    else $error("NOP carries class flags other than nop.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_payload.format_code == mipsdec_pkg::FMT_UNKNOWN |->
      out_payload.class_flags == mipsdec_pkg::FLAG_NONE)
    else $error("Unknown format carries class flags.");

endmodule

bind mips_instruction_decoder mipsdec_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (instr.valid),
  .in_ready    (instr.ready),
  .out_valid   (decoded.valid),
  .out_ready   (decoded.ready),
  .out_payload (decoded.payload)
);
